### rtl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked every cycle outside reset.
`define ILT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies consequence in the next.
`define ILT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ILT_ASSERT(lbl, clk, rst_n, prop, msg)
`define ILT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/ilt_pkg.sv
// Types, constants and byte-parsing functions of the IRC line tokenizer.
package ilt_pkg;

    localparam int MAX_PARAMS   = 15;
    localparam int MAX_NAME_LEN = 7;
    localparam int PCAP_INT     = (MAX_PARAMS > 15) ? 15 : MAX_PARAMS;
    localparam logic [3:0] PCAP = 4'(PCAP_INT);
    localparam int CMD_LEN_W    = $clog2(MAX_NAME_LEN + 1);
    localparam int NNAMES       = 13;
    localparam int SLOTS        = 3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_UNKNOWN = 4'd14;

    // Names right-justified, first character in the highest used byte
    localparam logic [63:0] NAME_STR [NNAMES] = '{
        "PASS", "PING", "PONG", "QUIT", "NICK", "USER", "PRIVMSG",
        "JOIN", "PART", "TOPIC", "INVITE", "KICK", "MODE"
    };
    localparam int NAME_LEN [NNAMES] = '{4, 4, 4, 4, 4, 4, 7, 4, 4, 5, 6, 4, 4};

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_PREFIX = 2'd1,
        PH_BODY   = 2'd2,
        PH_TRAIL  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_PREFIX  = 2'd0,
        ROLE_COMMAND = 2'd1,
        ROLE_MIDDLE  = 2'd2,
        ROLE_TRAIL   = 2'd3
    } t_role;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_phase                 phase;
        logic                   after_space;
        logic                   in_token;
        logic [3:0]             params;
        logic                   cmd_seen;
        logic [CMD_LEN_W-1:0]   cmd_len;
        logic                   cmd_long;
        logic [NNAMES-1:0]      name_hits;
        logic                   prefix;
        logic                   trailing;
        logic                   overflow;
    } t_line_state;

    localparam t_line_state LINE_CLEAR = '{
        phase: PH_START, after_space: 1'b0, in_token: 1'b0, params: '0,
        cmd_seen: 1'b0, cmd_len: '0, cmd_long: 1'b0, name_hits: '1,
        prefix: 1'b0, trailing: 1'b0, overflow: 1'b0
    };

    typedef struct packed {
        t_kind       item_kind;
        logic [7:0]  out_byte;
        t_role       byte_role;
        logic [3:0]  param_index;
        logic        token_start;
        logic [3:0]  command_code;
        logic [3:0]  param_count;
        logic        has_prefix;
        logic        has_trailing;
        logic        params_overflow;
        logic        last_of_run;
    } t_item;

    typedef struct packed {
        t_line_state st;
        logic        emit;
        t_item       item;
    } t_take;

    // Results of one processed request, packed from slot 0 upwards
    typedef struct packed {
        logic                 fire;
        logic [1:0]           count;
        t_item [SLOTS-1:0]    items;
    } t_batch;

    function automatic logic [7:0] name_char(int i, int p);
        logic [63:0] s;
        s = NAME_STR[i] >> (8 * (NAME_LEN[i] - 1 - p));
        return s[7:0];
    endfunction

    function automatic t_item byte_item(logic [7:0] b, t_role role, logic [3:0] idx,
                                        logic start);
        t_item it;
        it = '0;
        it.item_kind   = KIND_BYTE;
        it.out_byte    = b;
        it.byte_role   = role;
        it.param_index = idx;
        it.token_start = start;
        return it;
    endfunction

    function automatic t_line_state bump_params(t_line_state s);
        t_line_state r;
        r = s;
        if (!s.overflow && (s.params < PCAP)) begin
            r.params = s.params + 4'd1;
        end else begin
            r.overflow = 1'b1;
        end
        return r;
    endfunction

    function automatic t_take take_byte(t_line_state s, logic [7:0] b);
        t_take       r;
        t_phase      ph;
        logic        start;
        logic [7:0]  ub;
        int          pos;
        r      = '0;
        r.st   = s;
        r.emit = 1'b0;
        start  = !s.in_token;
        ub     = ((b >= CH_LA) && (b <= CH_LZ)) ? (b - CASE_GAP) : b;
        pos    = int'(s.cmd_len);
        if ((s.phase == PH_START) && (b == CH_COLON)) begin
            r.st.phase    = PH_PREFIX;
            r.st.prefix   = 1'b1;
            r.st.in_token = 1'b0;
        end else begin
            ph = (s.phase == PH_START) ? PH_BODY : s.phase;
            r.st.phase = ph;
            unique case (ph)
                PH_PREFIX: begin
                    if (b == CH_SP) begin
                        r.st.phase       = PH_BODY;
                        r.st.after_space = 1'b0;
                        r.st.in_token    = 1'b0;
                    end else begin
                        r.emit        = 1'b1;
                        r.item        = byte_item(b, ROLE_PREFIX, 4'd0, start);
                        r.st.in_token = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (!s.overflow) begin
                        r.emit        = 1'b1;
                        r.item        = byte_item(b, ROLE_TRAIL, s.params - 4'd1, start);
                        r.st.in_token = 1'b1;
                    end
                end
                PH_BODY, PH_START: begin
                    priority if (b == CH_SP) begin
                        r.st.after_space = 1'b1;
                        r.st.in_token    = 1'b0;
                    end else if ((b == CH_COLON) && s.after_space) begin
                        r.st          = bump_params(r.st);
                        r.st.phase    = PH_TRAIL;
                        r.st.trailing = 1'b1;
                        r.st.in_token = 1'b0;
                    end else begin
                        r.st.after_space = 1'b0;
                        if (start) begin
                            if (!s.cmd_seen) begin
                                r.st.cmd_seen = 1'b1;
                            end else begin
                                r.st = bump_params(r.st);
                            end
                            r.st.in_token = 1'b1;
                        end
                        if (r.st.params == 4'd0) begin
                            // command byte: match upper-cased byte at this position
                            if (pos >= MAX_NAME_LEN) begin
                                r.st.cmd_long = 1'b1;
                            end else begin
                                for (int i = 0; i < NNAMES; i++) begin
                                    if ((pos >= NAME_LEN[i]) || (name_char(i, pos) != ub)) begin
                                        r.st.name_hits[i] = 1'b0;
                                    end
                                end
                                r.st.cmd_len = s.cmd_len + CMD_LEN_W'(1);
                            end
                            r.emit = 1'b1;
                            r.item = byte_item(ub, ROLE_COMMAND, 4'd0, start);
                        end else if (!r.st.overflow) begin
                            r.emit = 1'b1;
                            r.item = byte_item(b, ROLE_MIDDLE, r.st.params - 4'd1, start);
                        end
                    end
                end
                default: begin
                    r.emit = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_item summary_item(t_line_state s);
        t_item      it;
        logic [3:0] code;
        it   = '0;
        code = CMD_NONE;
        if (s.cmd_seen) begin
            code = CMD_UNKNOWN;
            if (!s.cmd_long) begin
                // descending so the first listed name wins
                for (int i = NNAMES - 1; i >= 0; i--) begin
                    if (s.name_hits[i] && (s.cmd_len == CMD_LEN_W'(NAME_LEN[i]))) begin
                        code = 4'(i + 1);
                    end
                end
            end
        end
        it.item_kind       = KIND_SUMMARY;
        it.command_code    = code;
        it.param_count     = s.params;
        it.has_prefix      = s.prefix;
        it.has_trailing    = s.trailing;
        it.params_overflow = s.overflow;
        it.last_of_run     = 1'b1;
        return it;
    endfunction

endpackage

### rtl/ilt_req_if.sv
// Request channel: one raw byte of the line with its line-end flag.
interface ilt_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_line;

    modport source(output valid, output byte_value, output end_of_line, input ready);
    modport sink(input valid, input byte_value, input end_of_line, output ready);
endinterface

### rtl/ilt_res_if.sv
// Result channel: one kept byte or one line summary.
interface ilt_res_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] out_byte;
    logic [1:0] byte_role;
    logic [3:0] param_index;
    logic       token_start;
    logic [3:0] command_code;
    logic [3:0] param_count;
    logic       has_prefix;
    logic       has_trailing;
    logic       params_overflow;
    logic       last_of_run;

    modport source(output valid, output item_kind, output out_byte, output byte_role,
                   output param_index, output token_start, output command_code,
                   output param_count, output has_prefix, output has_trailing,
                   output params_overflow, output last_of_run, input ready);
    modport sink(input valid, input item_kind, input out_byte, input byte_role,
                 input param_index, input token_start, input command_code,
                 input param_count, input has_prefix, input has_trailing,
                 input params_overflow, input last_of_run, output ready);
endinterface

### rtl/ilt_core.sv
// Input register, line parsing state and per-request result assembly.
`include "assert_macros.svh"

module ilt_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ilt_req_if.sink        i_req,
    input  logic           i_load_ok,
    output ilt_pkg::t_batch o_batch
);
    import ilt_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eol;
    logic [7:0]  r_held_byte;
    logic        r_held_valid;
    t_line_state r_st;

    logic [7:0]  n_held_byte;
    logic        n_held_valid;
    t_line_state n_st;

    logic        proceed;
    logic        in_ready;
    logic        use_a;
    logic        use_c;
    logic        ea;
    logic        ec;
    logic        es;
    t_take       ta;
    t_take       tc;
    t_line_state s_mid;
    t_line_state s_end;
    t_item       sum_item;

    assign proceed     = r_in_valid && i_load_ok;
    assign in_ready    = !r_in_valid || proceed;
    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_in_byte <= i_req.byte_value;
            r_in_eol  <= i_req.end_of_line;
        end
    end

    always_comb begin
        // held byte is dropped when it is the CR of a final CR LF
        use_a = r_held_valid &&
                (!r_in_eol || (r_in_byte != CH_LF) || (r_held_byte != CH_CR));
        ta    = take_byte(r_st, r_held_byte);
        s_mid = use_a ? ta.st : r_st;
        ea    = use_a && ta.emit;

        use_c = r_in_eol && (r_in_byte != CH_LF);
        tc    = take_byte(s_mid, r_in_byte);
        s_end = use_c ? tc.st : s_mid;
        ec    = use_c && tc.emit;

        es       = r_in_eol;
        sum_item = summary_item(s_end);

        o_batch.fire     = proceed;
        o_batch.count    = 2'(ea) + 2'(ec) + 2'(es);
        o_batch.items[0] = ea ? ta.item : (ec ? tc.item : sum_item);
        o_batch.items[1] = (ea && ec) ? tc.item : sum_item;
        o_batch.items[2] = sum_item;

        n_st         = r_st;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        if (proceed) begin
            if (r_in_eol) begin
                n_st         = LINE_CLEAR;
                n_held_byte  = 8'd0;
                n_held_valid = 1'b0;
            end else begin
                n_st         = s_mid;
                n_held_byte  = r_in_byte;
                n_held_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= LINE_CLEAR;
            r_held_byte  <= 8'd0;
            r_held_valid <= 1'b0;
        end else begin
            r_st         <= n_st;
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
        end
    end

    `ILT_ASSERT(a_fire_needs_req, i_clk, i_rst_n, !o_batch.fire || r_in_valid, "fire without request")
    `ILT_ASSERT(a_mid_line_one, i_clk, i_rst_n, !(o_batch.fire && !r_in_eol) || (o_batch.count <= 2'd1), "mid-line request gave more than one result")
    `ILT_ASSERT_NEXT(a_eol_clears, i_clk, i_rst_n, o_batch.fire && r_in_eol, !r_held_valid && (r_st.phase == PH_START), "line state not cleared after line end")

endmodule

### rtl/ilt_out_buf.sv
// Three-slot result register, loaded with a whole batch, drained one per cycle on ready.
`include "assert_macros.svh"

module ilt_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ilt_pkg::t_batch i_batch,
    output logic            o_load_ok,
    ilt_res_if.source       o_res
);
    import ilt_pkg::*;

    t_item      r_slot [SLOTS];
    logic [1:0] r_cnt;
    logic       pop;

    assign pop       = (r_cnt != 2'd0) && o_res.ready;
    assign o_load_ok = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_batch.fire) begin
            r_cnt <= i_batch.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_batch.fire) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot[i] <= i_batch.items[i];
            end
        end else if (pop) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
                r_slot[i] <= r_slot[i + 1];
            end
        end
    end

    assign o_res.valid           = (r_cnt != 2'd0);
    assign o_res.item_kind       = r_slot[0].item_kind;
    assign o_res.out_byte        = r_slot[0].out_byte;
    assign o_res.byte_role       = r_slot[0].byte_role;
    assign o_res.param_index     = r_slot[0].param_index;
    assign o_res.token_start     = r_slot[0].token_start;
    assign o_res.command_code    = r_slot[0].command_code;
    assign o_res.param_count     = r_slot[0].param_count;
    assign o_res.has_prefix      = r_slot[0].has_prefix;
    assign o_res.has_trailing    = r_slot[0].has_trailing;
    assign o_res.params_overflow = r_slot[0].params_overflow;
    assign o_res.last_of_run     = r_slot[0].last_of_run;

    `ILT_ASSERT(a_load_has_room, i_clk, i_rst_n, !i_batch.fire || (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop), "batch loaded over pending results")
    `ILT_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, pop && !i_batch.fire, r_cnt == ($past(r_cnt) - 2'd1), "count not decremented on pop")
    `ILT_ASSERT(a_summary_closes, i_clk, i_rst_n, (r_cnt == 2'd0) || (r_slot[0].last_of_run == r_slot[0].item_kind), "summary flag mismatch")

endmodule

### rtl/irc_line_tokenizer_unit.sv
// Top level of the IRC line tokenizer: parsing core and result register.
// A request is registered in the input register, parsed combinationally and its results
// are loaded into the result register. Each byte is held until the next one arrives, so
// one request per cycle is taken mid-line while o_res is ready; a line-end request gives
// up to three results, one per cycle while o_res is ready, and the next request waits in
// the input register until all but the last have left.
// Synchronous active-low reset clears the line state, held byte and all queues.
module irc_line_tokenizer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ilt_req_if.sink   i_req,
    ilt_res_if.source o_res
);
    import ilt_pkg::*;

    t_batch batch;
    logic   load_ok;

    ilt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_load_ok(load_ok),
        .o_batch (batch)
    );

    ilt_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_batch  (batch),
        .o_load_ok(load_ok),
        .o_res    (o_res)
    );

endmodule

### sim/tb_irc_line_tokenizer_unit.sv
// Self-checking testbench of the IRC line tokenizer: random and directed lines, predicted tokens.
`timescale 1ns / 1ps

module tb_irc_line_tokenizer_unit;
    import ilt_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       last;
        bit         drain;
    } t_line_byte;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ilt_req_if req_ch ();
    ilt_res_if res_ch ();

    irc_line_tokenizer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    string irc_names [NNAMES] = '{
        "PASS", "PING", "PONG", "QUIT", "NICK", "USER", "PRIVMSG",
        "JOIN", "PART", "TOPIC", "INVITE", "KICK", "MODE"
    };

    t_line_byte  line_bytes [$];
    logic [7:0]  line_buf [$];
    t_item       predicted_tokens [$];
    bit          tokens_drained = 1'b1;
    int          mismatch_count = 0;

    // ---------------- token predictor ----------------
    t_phase            ln_phase = PH_START;
    bit                ln_after_space = 1'b0;
    bit                ln_in_token = 1'b0;
    logic [3:0]        ln_params = 4'd0;
    bit                ln_cmd_seen = 1'b0;
    int                ln_cmd_len = 0;
    bit                ln_cmd_long = 1'b0;
    logic [NNAMES-1:0] ln_matches = '1;
    bit                ln_prefix = 1'b0;
    bit                ln_trailing = 1'b0;
    bit                ln_overflow = 1'b0;
    logic [7:0]        held_char = 8'h00;
    bit                held_ok = 1'b0;

    task automatic clear_line_state();
        ln_phase       = PH_START;
        ln_after_space = 1'b0;
        ln_in_token    = 1'b0;
        ln_params      = 4'd0;
        ln_cmd_seen    = 1'b0;
        ln_cmd_len     = 0;
        ln_cmd_long    = 1'b0;
        ln_matches     = '1;
        ln_prefix      = 1'b0;
        ln_trailing    = 1'b0;
        ln_overflow    = 1'b0;
    endtask

    task automatic emit_token_byte(logic [7:0] b, t_role role, logic [3:0] idx, bit opens);
        t_item it;
        it             = '0;
        it.item_kind   = KIND_BYTE;
        it.out_byte    = b;
        it.byte_role   = role;
        it.param_index = idx;
        it.token_start = opens;
        predicted_tokens.insert(predicted_tokens.size(), it);
    endtask

    task automatic count_param();
        if (!ln_overflow && (ln_params < PCAP)) begin
            ln_params = ln_params + 4'd1;
        end else begin
            ln_overflow = 1'b1;
        end
    endtask

    task automatic match_name(logic [7:0] ub);
        if (ln_cmd_len >= MAX_NAME_LEN) begin
            ln_cmd_long = 1'b1;
        end else begin
            for (int i = 0; i < NNAMES; i++) begin
                if ((ln_cmd_len >= irc_names[i].len()) || (irc_names[i][ln_cmd_len] != ub)) begin
                    ln_matches[i] = 1'b0;
                end
            end
            ln_cmd_len++;
        end
    endtask

    task automatic tokenize_byte(logic [7:0] b);
        bit         opens;
        logic [7:0] ub;
        if (ln_phase == PH_START) begin
            if (b == CH_COLON) begin
                ln_phase    = PH_PREFIX;
                ln_prefix   = 1'b1;
                ln_in_token = 1'b0;
                return;
            end
            ln_phase = PH_BODY;
        end
        case (ln_phase)
            PH_PREFIX: begin
                if (b == CH_SP) begin
                    ln_phase       = PH_BODY;
                    ln_after_space = 1'b0;
                    ln_in_token    = 1'b0;
                end else begin
                    emit_token_byte(b, ROLE_PREFIX, 4'd0, !ln_in_token);
                    ln_in_token = 1'b1;
                end
            end
            PH_TRAIL: begin
                if (!ln_overflow) begin
                    emit_token_byte(b, ROLE_TRAIL, ln_params - 4'd1, !ln_in_token);
                    ln_in_token = 1'b1;
                end
            end
            default: begin
                if (b == CH_SP) begin
                    ln_after_space = 1'b1;
                    ln_in_token    = 1'b0;
                end else if ((b == CH_COLON) && ln_after_space) begin
                    ln_phase    = PH_TRAIL;
                    ln_trailing = 1'b1;
                    ln_in_token = 1'b0;
                    count_param();
                end else begin
                    ln_after_space = 1'b0;
                    opens = !ln_in_token;
                    if (opens) begin
                        if (!ln_cmd_seen) begin
                            ln_cmd_seen = 1'b1;
                        end else begin
                            count_param();
                        end
                        ln_in_token = 1'b1;
                    end
                    if (ln_params == 4'd0) begin
                        ub = ((b >= "a") && (b <= "z")) ? b - 8'h20 : b;
                        match_name(ub);
                        emit_token_byte(ub, ROLE_COMMAND, 4'd0, opens);
                    end else if (!ln_overflow) begin
                        emit_token_byte(b, ROLE_MIDDLE, ln_params - 4'd1, opens);
                    end
                end
            end
        endcase
    endtask

    task automatic emit_line_summary();
        t_item      it;
        logic [3:0] code;
        code = CMD_NONE;
        if (ln_cmd_seen) begin
            code = CMD_UNKNOWN;
            if (!ln_cmd_long) begin
                for (int i = NNAMES - 1; i >= 0; i--) begin
                    if (ln_matches[i] && (irc_names[i].len() == ln_cmd_len)) begin
                        code = 4'(i + 1);
                    end
                end
            end
        end
        it                 = '0;
        it.item_kind       = KIND_SUMMARY;
        it.command_code    = code;
        it.param_count     = ln_params;
        it.has_prefix      = ln_prefix;
        it.has_trailing    = ln_trailing;
        it.params_overflow = ln_overflow;
        it.last_of_run     = 1'b1;
        predicted_tokens.insert(predicted_tokens.size(), it);
    endtask

    // one byte is always held back so a closing CR LF or LF can be dropped
    task automatic parse_request(logic [7:0] b, logic last);
        if (!last) begin
            if (held_ok) begin
                tokenize_byte(held_char);
            end
            held_char = b;
            held_ok   = 1'b1;
        end else begin
            if (b == CH_LF) begin
                if (held_ok && (held_char != CH_CR)) begin
                    tokenize_byte(held_char);
                end
            end else begin
                if (held_ok) begin
                    tokenize_byte(held_char);
                end
                tokenize_byte(b);
            end
            emit_line_summary();
            held_ok   = 1'b0;
            held_char = 8'h00;
            clear_line_state();
        end
    endtask

    // ---------------- request driver ----------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : drive_requests
        t_line_byte nxt;
        if (!i_rst_n) begin
            req_ch.valid       <= 1'b0;
            req_ch.byte_value  <= 8'h00;
            req_ch.end_of_line <= 1'b0;
            burst_left         <= 0;
            gap_left           <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
                gap_left     <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end else if ((line_bytes.size() == 0) ||
                         (line_bytes[0].drain && (req_ch.valid || !tokens_drained))) begin
                req_ch.valid <= 1'b0;
            end else begin
                nxt = line_bytes.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.byte_value  <= nxt.value;
                req_ch.end_of_line <= nxt.last;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(0, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ---------------- result back-pressure ----------------
    logic [15:0] stall_pat = 16'hFFFF;
    int          stall_age = 0;

    always @(posedge i_clk) begin : drive_ready
        logic [15:0] fresh;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_pat    <= 16'hFFFF;
            stall_age    <= 0;
        end else if (stall_age == 0) begin
            case ($urandom_range(0, 3))
                0:       fresh = 16'hFFFF;
                1:       fresh = 16'($urandom);
                2:       fresh = 16'h8421;
                default: fresh = 16'($urandom) | 16'($urandom);
            endcase
            if (fresh == 16'h0000) begin
                fresh = 16'h0001;
            end
            stall_pat    <= fresh;
            stall_age    <= $urandom_range(20, 60);
            res_ch.ready <= fresh[0];
        end else begin
            stall_pat    <= {stall_pat[0], stall_pat[15:1]};
            stall_age    <= stall_age - 1;
            res_ch.ready <= stall_pat[1];
        end
    end

    // ---------------- result monitor ----------------
    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_item got;
        t_item want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.item_kind       = t_kind'(res_ch.item_kind);
                got.out_byte        = res_ch.out_byte;
                got.byte_role       = t_role'(res_ch.byte_role);
                got.param_index     = res_ch.param_index;
                got.token_start     = res_ch.token_start;
                got.command_code    = res_ch.command_code;
                got.param_count     = res_ch.param_count;
                got.has_prefix      = res_ch.has_prefix;
                got.has_trailing    = res_ch.has_trailing;
                got.params_overflow = res_ch.params_overflow;
                got.last_of_run     = res_ch.last_of_run;
                if (predicted_tokens.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
                             $time, got.item_kind, got.out_byte);
                    mismatch_count++;
                end else begin
                    want = predicted_tokens.pop_front();
                    check_field("item_kind", want.item_kind, got.item_kind);
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("byte_role", want.byte_role, got.byte_role);
                    check_field("param_index", want.param_index, got.param_index);
                    check_field("token_start", want.token_start, got.token_start);
                    check_field("command_code", want.command_code, got.command_code);
                    check_field("param_count", want.param_count, got.param_count);
                    check_field("has_prefix", want.has_prefix, got.has_prefix);
                    check_field("has_trailing", want.has_trailing, got.has_trailing);
                    check_field("params_overflow", want.params_overflow, got.params_overflow);
                    check_field("last_of_run", want.last_of_run, got.last_of_run);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                parse_request(req_ch.byte_value, req_ch.end_of_line);
            end
            tokens_drained <= (predicted_tokens.size() == 0);
        end
    end

    // ---------------- line building ----------------
    task automatic add_char(logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.insert(line_buf.size(), s[i]);
        end
    endtask

    task automatic send_line(bit drain);
        t_line_byte lb;
        if (line_buf.size() == 0) begin
            line_buf.insert(0, CH_LF);
        end
        foreach (line_buf[i]) begin
            lb.value = line_buf[i];
            lb.last  = (i == line_buf.size() - 1);
            lb.drain = drain && (i == 0);
            line_bytes.insert(line_bytes.size(), lb);
        end
        line_buf.delete();
    endtask

    task automatic send_text(string s);
        add_text(s);
        send_line(1'b0);
    endtask

    function automatic logic [7:0] token_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range("a", "z"));
            3, 4:    return 8'($urandom_range("A", "Z"));
            5:       return 8'($urandom_range("0", "9"));
            6:       return CH_COLON;
            7:       return 8'($urandom_range(8'h21, 8'hFF));
            8:       return 8'($urandom_range(8'h80, 8'hFF));
            default: return "#";
        endcase
    endfunction

    task automatic add_token(int max_len);
        repeat ($urandom_range(1, max_len)) add_char(token_char());
    endtask

    // known name in mixed case, now and then one letter longer or shorter, or a random token
    task automatic add_command();
        string nm;
        int    n;
        if ($urandom_range(0, 5) == 0) begin
            add_token(10);
        end else begin
            nm = irc_names[$urandom_range(0, NNAMES - 1)];
            n  = nm.len();
            case ($urandom_range(0, 5))
                0:       n = n - 1;
                1:       n = n + 1;
                default: ;
            endcase
            for (int i = 0; i < n; i++) begin
                if (i >= nm.len()) begin
                    add_char(8'($urandom_range("A", "Z")));
                end else if ($urandom_range(0, 1) == 1) begin
                    add_char(nm[i] + 8'h20);
                end else begin
                    add_char(nm[i]);
                end
            end
        end
    endtask

    task automatic add_random_line();
        int n_params;
        if ($urandom_range(0, 9) < 3) begin
            // noise: raw bytes rich in separators and line-end characters
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 5))
                    0:       add_char(CH_SP);
                    1:       add_char(CH_COLON);
                    2:       add_char(CH_CR);
                    3:       add_char(CH_LF);
                    4:       add_char(token_char());
                    default: add_char(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        if ($urandom_range(0, 2) == 0) begin
            add_char(CH_COLON);
            add_token(8);
            if ($urandom_range(0, 7) != 0) begin
                add_char(CH_SP);
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            add_command();
        end
        n_params = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 17) : $urandom_range(0, 4);
        repeat (n_params) begin
            repeat ($urandom_range(1, 2)) add_char(CH_SP);
            add_token(($urandom_range(0, 3) == 0) ? 6 : 2);
        end
        if ($urandom_range(0, 1) == 1) begin
            add_text(" :");
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(0, 4))
                    0:       add_char(CH_SP);
                    1:       add_char(CH_COLON);
                    default: add_char(token_char());
                endcase
            end
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: add_text("\r\n");
            5, 6:          add_char(CH_LF);
            7, 8:          ;
            default:       add_char(CH_CR);
        endcase
    endtask

    // ---------------- sequence and verdict ----------------
    initial begin
        int random_bytes;
        int before_line;

        send_text("PASS\r\n");
        send_text("ping x\n");
        send_text(":s.x PRIVMSG #c :hi\r\n");
        send_text("join #c\r");
        send_text("PRIVMSGX y");
        send_text(":nick!u@h");
        send_text(":p :x y\r\n");
        send_text(" :t r");
        send_text("CMD :\r\n");
        send_text("\n");
        send_text("\r\n");
        send_text(":");
        send_text("\r");
        send_text("X a b c d e f g h i j k l m n o p :z\r\n");
        // case folding edges around a-z, then all-ones and all-zero bytes
        add_char(8'h60);
        add_char(8'h61);
        add_char(8'h7A);
        add_char(8'h7B);
        add_char(CH_SP);
        add_char(8'hFF);
        add_char(8'h80);
        add_text(" :");
        add_char(8'h00);
        add_char(8'h7F);
        add_text("\r\n");
        send_line(1'b0);

        random_bytes = 0;
        while (random_bytes < 45) begin
            before_line = line_bytes.size();
            add_random_line();
            // first random line waits until every directed request has been answered
            send_line((random_bytes == 0) || ($urandom_range(0, 9) == 0));
            random_bytes += line_bytes.size() - before_line;
        end

        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while ((line_bytes.size() != 0) || req_ch.valid || (predicted_tokens.size() != 0));
        repeat (20) @(negedge i_clk);

        if ((mismatch_count == 0) && (predicted_tokens.size() == 0)) begin
            $display("RESULT: OK");
        end else begin
            if (predicted_tokens.size() != 0) begin
                $display("%0t: %0d results never arrived", $time, predicted_tokens.size());
            end
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d requests and %0d results outstanding",
                 $time, line_bytes.size(), predicted_tokens.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### irc_line_tokenizer_unit.f
+incdir+rtl
rtl/ilt_pkg.sv
rtl/ilt_req_if.sv
rtl/ilt_res_if.sv
rtl/ilt_core.sv
rtl/ilt_out_buf.sv
rtl/irc_line_tokenizer_unit.sv
sim/tb_irc_line_tokenizer_unit.sv
